[rtl/spf_pkg.sv]
package spf_pkg;

	localparam int unsigned NumWrites = 12;
	localparam int unsigned CntW      = 4;

	localparam logic [CntW-1:0] LastBeat = CntW'(NumWrites - 1);
	localparam logic [5:0]      TopAddr  = 6'd38;
	localparam logic [5:0]      LastAddr = 6'(38 - 2 * (NumWrites - 1));

	localparam logic [7:0] DashSeg    = 8'h08;
	localparam logic [7:0] DashTenths = 8'h10;
	localparam logic [7:0] IconBit    = 8'h80;
	localparam logic [7:0] PointBit   = 8'h01;
	localparam logic [7:0] AllOn      = 8'hFF;
	localparam logic [7:0] AllOff     = 8'h00;

	localparam logic [18:0] SecsPerHour = 19'd3600;
	localparam logic [6:0]  MaxHours    = 7'd99;
	localparam logic [3:0]  DigitZero   = 4'd0;

	// Register index, taken from paddr[2]
	localparam logic RegLayout = 1'b0;

	typedef struct packed {
		logic [13:0] temp_value;
		logic [18:0] time_value;
		logic [13:0] speed_value;
		logic        temp_blank;
		logic        time_blank;
		logic        speed_blank;
		logic        time_set_nonzero;
		logic        time_edit_mode;
		logic        protect_active;
		logic        protect_phase;
	} item_t;

	typedef struct packed {
		logic [5:0] lcd_address;
		logic [7:0] segment_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic temp_blank;
		logic time_blank;
		logic speed_blank;
		logic time_set;
		logic time_edit;
		logic prot;
		logic phase;
	} flags_t;

	typedef struct packed {
		logic nz;
		logic gt9;
		logic gt99;
		logic gt999;
	} mag_t;

	typedef struct packed {
		logic [3:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} bcd4_t;

	typedef struct packed {
		bcd4_t      temp;
		mag_t       temp_mag;
		bcd4_t      speed;
		mag_t       speed_mag;
		logic [3:0] hr_tens;
		logic [3:0] hr_ones;
		logic [5:0] minutes;
		logic       time_nz;
		flags_t     flags;
	} digits_t;

	typedef logic [NumWrites-1:0][7:0] panel_t;

	// Quotient by ten via reciprocal, exact for every 8-bit v
	function automatic logic [4:0] div10(input logic [7:0] v);
		logic [15:0] p;
		p = 16'(v) * 16'd205;
		return p[15:11];
	endfunction

	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [7:0] r;
		r = v - 8'(div10(v)) * 8'd10;
		return r[3:0];
	endfunction

	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'h77;
			4'd1: s = 8'h12;
			4'd2: s = 8'h5D;
			4'd3: s = 8'h5B;
			4'd4: s = 8'h3A;
			4'd5: s = 8'h6B;
			4'd6: s = 8'h6F;
			4'd7: s = 8'h52;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h7B;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] seg_tenths(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hEE;
			4'd1: s = 8'h24;
			4'd2: s = 8'hBA;
			4'd3: s = 8'hB6;
			4'd4: s = 8'h74;
			4'd5: s = 8'hD6;
			4'd6: s = 8'hDE;
			4'd7: s = 8'hA4;
			4'd8: s = 8'hFE;
			4'd9: s = 8'hF6;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

[rtl/spf_arith.sv]
module spf_arith import spf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_item,
	output logic    out_valid,
	input  logic    out_ready,
	output digits_t out_digits
);

	function automatic mag_t magnitude(input logic [13:0] v);
		mag_t m;
		m.nz    = (v != 14'd0);
		m.gt9   = (v > 14'd9);
		m.gt99  = (v > 14'd99);
		m.gt999 = (v > 14'd999);
		return m;
	endfunction

	// Hundreds count c (below 164) and remainder lo (below 100) to four digits
	function automatic bcd4_t split_bcd(input logic [7:0] c, input logic [6:0] lo);
		bcd4_t      b;
		logic [4:0] q;
		q      = div10(c);
		b.thou = (q >= 5'd10) ? 4'(q - 5'd10) : q[3:0];
		b.hund = mod10(c);
		b.tens = 4'(div10({1'b0, lo}));
		b.ones = mod10({1'b0, lo});
		return b;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// Stage 1: hundreds of temperature and speed, raw hours
	logic [27:0] temp_prod, spd_prod;
	logic [30:0] hr_prod;

	assign temp_prod = 28'(in_item.temp_value[13:2]) * 28'd2622;
	assign spd_prod  = 28'(in_item.speed_value[13:2]) * 28'd2622;
	assign hr_prod   = 31'(in_item.time_value[18:4]) * 31'd37283;

	logic [13:0] temp_s1, spd_s1;
	logic [18:0] time_s1;
	logic [7:0]  temp_c_s1, spd_c_s1, hr_s1;
	mag_t        temp_mag_s1, spd_mag_s1;
	logic        time_nz_s1;
	flags_t      flags_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			temp_s1     <= in_item.temp_value;
			spd_s1      <= in_item.speed_value;
			time_s1     <= in_item.time_value;
			temp_c_s1   <= temp_prod[23:16];
			spd_c_s1    <= spd_prod[23:16];
			hr_s1       <= hr_prod[30:23];
			temp_mag_s1 <= magnitude(in_item.temp_value);
			spd_mag_s1  <= magnitude(in_item.speed_value);
			time_nz_s1  <= (in_item.time_value != 19'd0);
			flags_s1    <= '{temp_blank: in_item.temp_blank,
			                 time_blank: in_item.time_blank,
			                 speed_blank: in_item.speed_blank,
			                 time_set: in_item.time_set_nonzero,
			                 time_edit: in_item.time_edit_mode,
			                 prot: in_item.protect_active,
			                 phase: in_item.protect_phase};
		end
	end

	// Stage 2: remainders below one hundred and one hour, clamp hours
	logic [13:0] temp_lo_full, spd_lo_full;
	logic [18:0] rem_full;

	assign temp_lo_full = temp_s1 - 14'(temp_c_s1) * 14'd100;
	assign spd_lo_full  = spd_s1 - 14'(spd_c_s1) * 14'd100;
	assign rem_full     = time_s1 - 19'(hr_s1) * SecsPerHour;

	logic [7:0]  temp_c_s2, spd_c_s2;
	logic [6:0]  temp_lo_s2, spd_lo_s2, hr_s2;
	logic [11:0] rem_s2;
	mag_t        temp_mag_s2, spd_mag_s2;
	logic        time_nz_s2;
	flags_t      flags_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			temp_c_s2   <= temp_c_s1;
			spd_c_s2    <= spd_c_s1;
			temp_lo_s2  <= temp_lo_full[6:0];
			spd_lo_s2   <= spd_lo_full[6:0];
			hr_s2       <= (hr_s1 > 8'(MaxHours)) ? MaxHours : hr_s1[6:0];
			rem_s2      <= rem_full[11:0];
			temp_mag_s2 <= temp_mag_s1;
			spd_mag_s2  <= spd_mag_s1;
			time_nz_s2  <= time_nz_s1;
			flags_s2    <= flags_s1;
		end
	end

	// Stage 3: decimal digits and whole minutes
	logic [19:0] min_prod;
	digits_t     digits_next;

	assign min_prod = 20'(rem_s2[11:2]) * 20'd1093;

	always_comb begin
		digits_next.temp      = split_bcd(temp_c_s2, temp_lo_s2);
		digits_next.temp_mag  = temp_mag_s2;
		digits_next.speed     = split_bcd(spd_c_s2, spd_lo_s2);
		digits_next.speed_mag = spd_mag_s2;
		digits_next.hr_tens   = 4'(div10({1'b0, hr_s2}));
		digits_next.hr_ones   = mod10({1'b0, hr_s2});
		digits_next.minutes   = min_prod[19:14];
		digits_next.time_nz   = time_nz_s2;
		digits_next.flags     = flags_s2;
	end

	digits_t digits_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) digits_s3 <= digits_next;
	end

	assign out_digits = digits_s3;

endmodule

[rtl/spf_compose.sv]
module spf_compose import spf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    layout,
	input  logic    in_valid,
	output logic    in_ready,
	input  digits_t in_digits,
	output logic    out_valid,
	input  logic    out_ready,
	output panel_t  out_panel
);

	logic   v_s4, rdy_s4;
	panel_t panel_s4;
	panel_t s;
	logic [7:0] tseg [4];
	flags_t f;
	logic   show;

	assign rdy_s4    = !v_s4 || out_ready;
	assign in_ready  = rdy_s4;
	assign out_valid = v_s4;
	assign out_panel = panel_s4;

	assign f    = in_digits.flags;
	assign show = f.time_set || f.time_edit;

	always_comb begin
		tseg[0] = seg_digit(in_digits.hr_tens);
		tseg[1] = seg_digit(in_digits.hr_ones);
		tseg[2] = seg_digit(4'(div10({2'b00, in_digits.minutes})));
		tseg[3] = seg_digit(mod10({2'b00, in_digits.minutes}));
	end

	always_comb begin
		s = '0;

		if (!f.temp_blank) begin
			if (in_digits.temp_mag.nz) begin
				s[0] = in_digits.temp_mag.gt999 ? seg_digit(in_digits.temp.thou) : AllOff;
				s[1] = in_digits.temp_mag.gt99 ? seg_digit(in_digits.temp.hund) : AllOff;
				s[2] = in_digits.temp_mag.gt9 ? seg_digit(in_digits.temp.tens)
				                              : seg_digit(DigitZero);
				s[3] = seg_tenths(in_digits.temp.ones) | PointBit;
			end else begin
				s[0] = DashSeg;
				s[1] = DashSeg;
				s[2] = DashSeg;
				s[3] = DashTenths;
			end
		end
		s[2] = s[2] | IconBit;

		if (!layout) begin
			if (!f.time_blank) begin
				for (int k = 0; k < 4; k++) begin
					s[8 + k] = in_digits.time_nz ? tseg[k] : DashSeg;
				end
			end
			s[9]  = s[9] | IconBit;
			s[11] = s[11] | IconBit;
		end else begin
			if (show && !f.time_blank) begin
				for (int k = 0; k < 4; k++) begin
					s[4 + k] = f.time_set ? tseg[k] : DashSeg;
				end
			end
			if (show) begin
				s[5] = s[5] | IconBit;
				s[6] = s[6] | IconBit;
			end
			if (!f.speed_blank) begin
				if (in_digits.speed_mag.nz) begin
					s[8]  = in_digits.speed_mag.gt999 ? seg_digit(in_digits.speed.thou)
					                                  : AllOff;
					s[9]  = in_digits.speed_mag.gt99 ? seg_digit(in_digits.speed.hund)
					                                 : AllOff;
					s[10] = in_digits.speed_mag.gt9 ? seg_digit(in_digits.speed.tens)
					                                : AllOff;
					s[11] = seg_digit(in_digits.speed.ones);
				end else begin
					for (int k = 8; k < 12; k++) begin
						s[k] = DashSeg;
					end
				end
			end
			s[10] = s[10] | IconBit;
		end

		// Alarm overrides the whole panel
		if (f.prot) begin
			for (int k = 0; k < NumWrites; k++) begin
				s[k] = f.phase ? AllOn : AllOff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) panel_s4 <= s;
	end

endmodule

[rtl/spf_serialiser.sv]
module spf_serialiser import spf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   load_valid,
	output logic   load_ready,
	input  panel_t load_panel,
	output logic   result_strobe,
	output res_t   result
);

	logic            active_q;
	logic [CntW-1:0] cnt_q;
	logic [5:0]      addr_q;
	panel_t          bytes_q;
	logic            at_last;
	logic            load;

	assign at_last    = (cnt_q == LastBeat);
	assign load_ready = !active_q || at_last;
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			if (at_last) active_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Drop the byte just sent, advance the address
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_panel;
			addr_q  <= TopAddr;
		end else if (active_q) begin
			bytes_q <= {AllOff, bytes_q[NumWrites-1:1]};
			addr_q  <= addr_q - 6'd2;
		end
	end

	assign result_strobe       = active_q;
	assign result.lcd_address  = addr_q;
	assign result.segment_byte = bytes_q[0];
	assign result.last         = at_last;

	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> result.lcd_address == LastAddr)
		else $error("last write not at bottom address");

	a_burst_runs: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !at_last |=> active_q && cnt_q == $past(cnt_q) + 1'b1)
		else $error("write burst broken early");

	a_burst_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(cnt_q) == LastBeat)
		else $error("burst ended short of twelve writes");

	a_load_addr: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> addr_q == TopAddr && result_strobe)
		else $error("burst did not start at top address");

endmodule

[rtl/segment_panel_formatter.sv]
// Segment panel formatter. Each item is one panel update, and it turns into a
// burst of twelve segment-RAM writes at addresses 38, 36, ... 16, one write per
// cycle on result_strobe, with result.last set on the twelfth. The receiver has
// no way to hold writes off, so a burst always runs to its end without gaps.
// An accepted item passes through three arithmetic stages (hundreds and hours
// by reciprocal multiply, remainders, decimal digits), one stage that builds
// the twelve bytes, then the output shift register. Items may arrive in
// successive cycles; the four stages ahead of the shift register buffer them,
// and start is taken whenever busy is low. Sustained throughput is set by the
// single write port that drains the shift register; the next burst follows
// the previous one with no idle cycle in between. The layout register (byte
// address 0 on the APB port) picks the panel: 0 for temperature and time, 1
// for temperature, time and speed. Write it only while no update is in
// flight.
module segment_panel_formatter import spf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        result_strobe,
	output res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic    layout_q;
	logic    arith_ready;
	logic    digits_valid, digits_ready;
	digits_t digits;
	logic    panel_valid, panel_ready;
	panel_t  panel;
	logic    reg_sel;

	// Configuration port: no wait states, one register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == RegLayout);
	assign prdata  = reg_sel ? 32'(layout_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			layout_q <= pwdata[0];
		end
	end

	// Hold off new items only when the first stage cannot advance
	assign busy = !arith_ready;

	spf_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_ready  (arith_ready),
		.in_item   (item),
		.out_valid (digits_valid),
		.out_ready (digits_ready),
		.out_digits(digits)
	);

	spf_compose u_compose (
		.clk       (clk),
		.arst_n    (arst_n),
		.layout    (layout_q),
		.in_valid  (digits_valid),
		.in_ready  (digits_ready),
		.in_digits (digits),
		.out_valid (panel_valid),
		.out_ready (panel_ready),
		.out_panel (panel)
	);

	spf_serialiser u_serialiser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (panel_valid),
		.load_ready   (panel_ready),
		.load_panel   (panel),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule

[verif/segment_panel_checker.sv]
`timescale 1ns / 100ps

module segment_panel_checker import spf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  item_t       item,
	input  logic        result_strobe,
	input  res_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending,
	output int          writes_checked
);

	typedef logic [3:0][7:0] quad_t;

	localparam int ReportLimit = 10;

	// Seven-segment patterns, entry d at index d
	localparam logic [9:0][7:0] DigitSegs = {
		8'h7B, 8'h7F, 8'h52, 8'h6F, 8'h6B, 8'h3A, 8'h5B, 8'h5D, 8'h12, 8'h77
	};
	localparam logic [9:0][7:0] TenthSegs = {
		8'hF6, 8'hFE, 8'hA4, 8'hDE, 8'hD6, 8'h74, 8'hB6, 8'hBA, 8'h24, 8'hEE
	};
	localparam quad_t DashQuad = {4{DashSeg}};

	res_t expected_writes[$];
	logic speed_panel;
	int   n_bad;
	int   n_seen;

	// Four digit places, leading places blanked; lead_zero_tens keeps a zero in the tens place
	function automatic quad_t digit_quad(input int unsigned v, input logic lead_zero_tens);
		quad_t q;
		q[0] = (v > 999) ? DigitSegs[(v / 1000) % 10] : AllOff;
		q[1] = (v > 99) ? DigitSegs[(v / 100) % 10] : AllOff;
		q[2] = (v > 9) ? DigitSegs[(v / 10) % 10] : (lead_zero_tens ? DigitSegs[0] : AllOff);
		q[3] = DigitSegs[v % 10];
		return q;
	endfunction

	function automatic quad_t clock_quad(input int unsigned secs);
		quad_t       q;
		int unsigned hrs;
		int unsigned mins;
		hrs  = secs / 3600;
		mins = (secs % 3600) / 60;
		if (hrs > 99)
			hrs = 99;
		q[0] = DigitSegs[hrs / 10];
		q[1] = DigitSegs[hrs % 10];
		q[2] = DigitSegs[mins / 10];
		q[3] = DigitSegs[mins % 10];
		return q;
	endfunction

	function automatic panel_t format_panel(input item_t u, input logic with_speed);
		panel_t p;
		logic   show_time;
		p = '0;
		if (!u.temp_blank) begin
			if (u.temp_value != 0) begin
				p[3:0] = digit_quad(32'(u.temp_value), 1'b1);
				p[3]   = TenthSegs[u.temp_value % 10] | PointBit;
			end else begin
				p[3:0] = DashQuad;
				p[3]   = DashTenths;
			end
		end
		p[2] = p[2] | IconBit;
		if (!with_speed) begin
			if (!u.time_blank)
				p[11:8] = (u.time_value != 0) ? clock_quad(32'(u.time_value)) : DashQuad;
			p[9]  = p[9] | IconBit;
			p[11] = p[11] | IconBit;
		end else begin
			show_time = u.time_set_nonzero | u.time_edit_mode;
			if (show_time && !u.time_blank)
				p[7:4] = u.time_set_nonzero ? clock_quad(32'(u.time_value)) : DashQuad;
			if (show_time) begin
				p[5] = p[5] | IconBit;
				p[6] = p[6] | IconBit;
			end
			if (!u.speed_blank)
				p[11:8] = (u.speed_value != 0) ? digit_quad(32'(u.speed_value), 1'b0)
				                               : DashQuad;
			p[10] = p[10] | IconBit;
		end
		if (u.protect_active)
			p = u.protect_phase ? {NumWrites{AllOn}} : {NumWrites{AllOff}};
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		panel_t panel;
		res_t   w;
		res_t   got;
		if (!arst_n) begin
			expected_writes.delete();
			speed_panel = 1'b0;
			n_bad       = 0;
			n_seen      = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == RegLayout)
				speed_panel = pwdata[0];
			if (start && !busy) begin
				panel = format_panel(item, speed_panel);
				for (int k = 0; k < NumWrites; k++) begin
					w.lcd_address  = TopAddr - 6'(2 * k);
					w.segment_byte = panel[k];
					w.last         = (k == NumWrites - 1);
					expected_writes.push_back(w);
				end
			end
			if (result_strobe) begin
				got = result;
				n_seen++;
				if (expected_writes.size() == 0) begin
					n_bad++;
					if (n_bad <= ReportLimit)
						$display("unexpected segment write: addr %0d byte %02h last %0b",
							got.lcd_address, got.segment_byte, got.last);
				end else begin
					w = expected_writes.pop_front();
					if (got.lcd_address !== w.lcd_address || got.segment_byte !== w.segment_byte ||
						got.last !== w.last) begin
						n_bad++;
						if (n_bad <= ReportLimit)
							$display({"segment write %0d: expected addr %0d byte %02h last %0b,",
								" got addr %0d byte %02h last %0b"},
								n_seen, w.lcd_address, w.segment_byte, w.last,
								got.lcd_address, got.segment_byte, got.last);
					end
				end
			end
		end
		mismatches     <= n_bad;
		pending        <= expected_writes.size();
		writes_checked <= n_seen;
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top import spf_pkg::*; ();

	// Layout register codes and bus addresses
	localparam logic       LayoutSpeed     = 1'b1;
	localparam logic [2:0] LayoutAddr      = {RegLayout, 2'b00};
	localparam logic [2:0] SpareAddr       = {~RegLayout, 2'b00};

	// Flag masks, in item field order
	localparam logic [6:0] FTempBlank  = 7'b1000000;
	localparam logic [6:0] FTimeBlank  = 7'b0100000;
	localparam logic [6:0] FSpeedBlank = 7'b0010000;
	localparam logic [6:0] FTimeSet    = 7'b0001000;
	localparam logic [6:0] FTimeEdit   = 7'b0000100;
	localparam logic [6:0] FProtect    = 7'b0000010;
	localparam logic [6:0] FPhase      = 7'b0000001;

	localparam int NumPhases     = 4;
	localparam int PhaseItems    = 25;
	localparam int SettleCycles  = 8;
	localparam int QuietLimit    = 2000;

	// Per phase: layout and the sender's idle percentage
	localparam logic [NumPhases-1:0]      PhaseLayout = 4'b0101;
	localparam logic [NumPhases-1:0][6:0] PhaseIdle   = {7'd47, 7'd11, 7'd47, 7'd0};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        result_strobe;
	res_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int writes_checked;
	int n_sent;
	int idle_pct;
	int quiet_cycles;

	segment_panel_formatter i_dut (
		.clk, .arst_n, .start, .busy, .item, .result_strobe, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	segment_panel_checker i_checker (
		.clk, .arst_n, .start, .busy, .item, .result_strobe, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.mismatches, .pending, .writes_checked
	);

	always #1 clk = ~clk;

	// Watchdog: end the run if nothing moves on any port for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe || (psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QuietLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t panel_update(input int unsigned temp, input int unsigned secs,
		input int unsigned speed, input logic [6:0] flags);
		return {14'(temp), 19'(secs), 14'(speed), flags};
	endfunction

	// Readings lean towards zero and small values; a few overflow four digits
	function automatic logic [13:0] pick_reading();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return '0;
		if (roll < 30)
			return 14'($urandom_range(99));
		if (roll < 90)
			return 14'($urandom_range(9999));
		return 14'($urandom_range(16383));
	endfunction

	function automatic logic [18:0] pick_seconds();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return '0;
		if (roll < 25)
			return 19'($urandom_range(3599));
		if (roll < 90)
			return 19'($urandom_range(359999));
		return 19'($urandom_range(524287));
	endfunction

	function automatic item_t random_update();
		item_t u;
		u.temp_value       = pick_reading();
		u.time_value       = pick_seconds();
		u.speed_value      = pick_reading();
		u.temp_blank       = $urandom_range(99) < 15;
		u.time_blank       = $urandom_range(99) < 15;
		u.speed_blank      = $urandom_range(99) < 15;
		u.time_set_nonzero = $urandom_range(99) < 50;
		u.time_edit_mode   = $urandom_range(99) < 40;
		u.protect_active   = $urandom_range(99) < 12;
		u.protect_phase    = 1'($urandom_range(1));
		return u;
	endfunction

	// Hold start high until the block takes the item; leave it high for the caller
	task automatic send_update(input item_t u);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= u;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drop start, wait for every expected write, then let the pipeline run dry
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		quiet_cycles = 0;
		n_sent       = 0;
		idle_pct     = 11;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Temperature and time panel, straight out of reset
		send_update(panel_update(0, 0, 0, '0));                 // zero values show dashes
		send_update(panel_update(9999, 359999, 9999, '0));      // largest four-digit values, 99:59
		send_update(panel_update(1, 59, 0, '0));                // tens zero kept; under a minute
		send_update(panel_update(10, 3600, 1, '0));
		send_update(panel_update(100, 60, 0, '0));
		send_update(panel_update(1000, 86399, 0, '0));
		// five-digit temperature, hours above 99, speed ignored on this panel
		send_update(panel_update(16383, 524287, 16383, FTimeSet | FTimeEdit | FSpeedBlank));
		send_update(panel_update(1234, 4000, 0, FTempBlank));
		send_update(panel_update(1234, 4000, 0, FTimeBlank));
		send_update(panel_update(5678, 7200, 42, FProtect | FPhase));
		send_update(panel_update(5678, 7200, 42, FProtect));
		send_update(panel_update(16383, 524287, 16383, 7'h7F));
		settle();

		// A write to the unused register slot must leave the layout alone
		apb_write(SpareAddr, 32'hFFFF_FFFF);
		send_update(panel_update(250, 123456, 77, FTimeSet));
		settle();

		// Temperature, time and speed panel
		apb_write(LayoutAddr, {31'h7FFF_FFFF, LayoutSpeed});
		send_update(panel_update(0, 0, 0, FTimeSet));           // time set at zero shows 00:00
		send_update(panel_update(9999, 359999, 9999, FTimeSet));
		send_update(panel_update(1, 0, 5, FTimeEdit));          // editing, no setpoint: dashes
		send_update(panel_update(37, 5000, 10, '0));            // time hidden entirely
		send_update(panel_update(37, 5000, 999, FTimeSet | FTimeEdit | FTimeBlank));
		send_update(panel_update(37, 524287, 16383, FTimeSet));
		send_update(panel_update(37, 5000, 1234, FSpeedBlank | FTempBlank | FTimeEdit));
		send_update(panel_update(800, 5000, 1234, FProtect | FPhase | FTimeSet));
		send_update(panel_update(800, 5000, 1234, FProtect));

		// Random phases: alternate layouts, vary the sender's gaps
		for (int ph = 0; ph < NumPhases; ph++) begin
			settle();
			apb_write(LayoutAddr, {31'($urandom() >> 1), PhaseLayout[ph]});
			idle_pct = int'(PhaseIdle[ph]);
			for (int n = 0; n < PhaseItems; n++)
				send_update(random_update());
		end

		settle();
		$display("Sent %0d panel updates across both layouts, with and without sender gaps;",
			n_sent);
		$display("%0d segment writes compared against the predicted panel.", writes_checked);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
